/* design/levenshtein_distance_assert.svh */
// ----------------------------------------------------------------------------
// Levenshtein distance assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LEVENSHTEIN_DISTANCE_ASSERT_SVH
`define LEVENSHTEIN_DISTANCE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define LD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* design/lvd_pkg.sv */
// ----------------------------------------------------------------------------
// Levenshtein distance package
// Field widths, beat modes and controller states of the edit distance engine.
// ----------------------------------------------------------------------------
package lvd_pkg;

	localparam int MODE_W = 2;
	localparam int SYM_W  = 16;
	localparam int DIST_W = 7;

	// Largest distance the result field can carry.
	localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

	// Operation carried by an input beat; the fourth code is ignored.
	typedef enum logic [MODE_W-1:0] {
		MODE_FIRST   = 2'd0,
		MODE_SECOND  = 2'd1,
		MODE_COMPUTE = 2'd2
	} mode_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_SWEEP,
		ST_RESULT
	} state_t;

endpackage

/* design/lvd_if.sv */
// ----------------------------------------------------------------------------
// Levenshtein distance channels
// Valid/ready channels for input beats and for distance results.
// ----------------------------------------------------------------------------

// Input channel: one character or one compute request per beat.
interface lvd_in_if;
	logic                     valid;
	logic                     ready;
	logic [lvd_pkg::MODE_W-1:0] mode;
	logic [lvd_pkg::SYM_W-1:0]  symbol;

	modport source (output valid, output mode, output symbol, input ready);
	modport sink   (input valid, input mode, input symbol, output ready);
endinterface

// Output channel: one distance result per beat.
interface lvd_out_if;
	logic                       valid;
	logic                       ready;
	logic [lvd_pkg::DIST_W-1:0] distance;
	logic                       overflowed;

	modport source (output valid, output distance, output overflowed, input ready);
	modport sink   (input valid, input distance, input overflowed, output ready);
endinterface

/* design/levenshtein_distance.sv */
// A character beat is stored when it is taken; loads are taken back to back while idle.
// A compute beat holds off the input while the engine sweeps the strings (n1, n2 the
// string lengths; no sweep if either is empty), with one read-modify-write of the
// cost row memory per matrix cell plus one row setup state per row.
// The result then sits in an output register; loads continue while it waits.
// Reset clears counters, drop flag and control; the memories are not cleared.
// ----------------------------------------------------------------------------
// Levenshtein distance engine
// Stores two strings in memories and sweeps a single cost row to get the
// edit distance, with unit cost for insertion, deletion and substitution.
// ----------------------------------------------------------------------------
`include "levenshtein_distance_assert.svh"

module levenshtein_distance #(
	parameter int MAX_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	lvd_in_if.sink      req,
	lvd_out_if.source   rsp
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int XW = (CW > lvd_pkg::DIST_W) ? CW : lvd_pkg::DIST_W;

	lvd_pkg::state_t state_q, state_nxt;

	logic [CW-1:0] cnt1_q, cnt2_q;
	logic          drop_q;
	logic [CW-1:0] n1_q, n2_q;
	logic          ovf_q;
	logic [CW-1:0] i_q, j_q;
	logic [CW-1:0] left_q, diag_q;
	logic [CW-1:0] res_q;

	logic                        out_vld_q;
	logic [lvd_pkg::DIST_W-1:0]  out_dist_q;
	logic                        out_ovf_q;

	// String and cost row storage.
	logic [lvd_pkg::SYM_W-1:0] ftext_mem [MAX_LEN];
	logic [lvd_pkg::SYM_W-1:0] stext_mem [MAX_LEN];
	logic [CW-1:0]             row_mem   [MAX_LEN];
	logic [lvd_pkg::SYM_W-1:0] ftext_rd_q, stext_rd_q;
	logic [CW-1:0]             row_rd_q;

	logic          acc, load1, load2, start, empty;
	logic          ft_rd_en, col_rd_en, row_we, out_load;
	logic [CW-1:0] ft_rd_idx, col_rd_idx, row_wr_idx;
	logic [CW-1:0] up;
	logic [CW:0]   c_up, c_left, c_sub, c_min;
	logic [CW-1:0] cost;
	logic [XW-1:0] res_ext;
	logic          row_last, sweep_last;

	// Input beat decode.
	assign req.ready = (state_q == lvd_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign empty     = (cnt1_q == '0) || (cnt2_q == '0);

	always_comb begin
		load1 = 1'b0;
		load2 = 1'b0;
		start = 1'b0;
		case (req.mode)
			lvd_pkg::MODE_FIRST:   load1 = acc;
			lvd_pkg::MODE_SECOND:  load2 = acc;
			lvd_pkg::MODE_COMPUTE: start = acc;
			default: ;
		endcase
	end

	// Cell update: minimum of deletion, insertion and substitution costs.
	assign up     = (i_q == CW'(1)) ? j_q : row_rd_q;
	assign c_up   = {1'b0, up} + 1'b1;
	assign c_left = {1'b0, left_q} + 1'b1;
	assign c_sub  = {1'b0, diag_q} + {{CW{1'b0}}, (ftext_rd_q != stext_rd_q)};

	always_comb begin
		c_min = (c_up < c_left) ? c_up : c_left;
		if (c_sub < c_min) begin
			c_min = c_sub;
		end
	end

	assign cost       = c_min[CW-1:0];
	assign row_last   = (j_q == n2_q);
	assign sweep_last = row_last && (i_q == n1_q);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lvd_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = empty ? lvd_pkg::ST_RESULT : lvd_pkg::ST_ROW;
				end
			end
			lvd_pkg::ST_ROW: begin
				state_nxt = lvd_pkg::ST_SWEEP;
			end
			lvd_pkg::ST_SWEEP: begin
				if (row_last) begin
					state_nxt = sweep_last ? lvd_pkg::ST_RESULT : lvd_pkg::ST_ROW;
				end
			end
			lvd_pkg::ST_RESULT: begin
				if (!out_vld_q || rsp.ready) begin
					state_nxt = lvd_pkg::ST_IDLE;
				end
			end
			default: state_nxt = lvd_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and result load.
	always_comb begin
		ft_rd_en   = 1'b0;
		col_rd_en  = 1'b0;
		row_we     = 1'b0;
		out_load   = 1'b0;
		ft_rd_idx  = i_q - 1'b1;
		col_rd_idx = '0;
		row_wr_idx = j_q - 1'b1;
		unique case (state_q)
			lvd_pkg::ST_IDLE: ;
			lvd_pkg::ST_ROW: begin
				ft_rd_en  = 1'b1;
				col_rd_en = 1'b1;
			end
			lvd_pkg::ST_SWEEP: begin
				row_we     = 1'b1;
				col_rd_en  = !row_last;
				col_rd_idx = j_q;
			end
			lvd_pkg::ST_RESULT: begin
				out_load = !out_vld_q || rsp.ready;
			end
			default: ;
		endcase
	end

	// First string memory.
	always_ff @(posedge clk) begin
		if (load1 && (cnt1_q < CW'(MAX_LEN))) begin
			ftext_mem[cnt1_q[AW-1:0]] <= req.symbol;
		end
		if (ft_rd_en) begin
			ftext_rd_q <= ftext_mem[ft_rd_idx[AW-1:0]];
		end
	end

	// Second string memory, read one column ahead of the sweep.
	always_ff @(posedge clk) begin
		if (load2 && (cnt2_q < CW'(MAX_LEN))) begin
			stext_mem[cnt2_q[AW-1:0]] <= req.symbol;
		end
		if (col_rd_en) begin
			stext_rd_q <= stext_mem[col_rd_idx[AW-1:0]];
		end
	end

	// Cost row memory; entry j-1 holds column j of the current row.
	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wr_idx[AW-1:0]] <= cost;
		end
		if (col_rd_en) begin
			row_rd_q <= row_mem[col_rd_idx[AW-1:0]];
		end
	end

	// Controller state and string counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvd_pkg::ST_IDLE;
			cnt1_q  <= '0;
			cnt2_q  <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (load1) begin
				if (cnt1_q < CW'(MAX_LEN)) begin
					cnt1_q <= cnt1_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (load2) begin
				if (cnt2_q < CW'(MAX_LEN)) begin
					cnt2_q <= cnt2_q + 1'b1;
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (start) begin
				cnt1_q <= '0;
				cnt2_q <= '0;
				drop_q <= 1'b0;
				i_q    <= CW'(1);
			end
			if (state_q == lvd_pkg::ST_ROW) begin
				j_q <= CW'(1);
			end
			if (state_q == lvd_pkg::ST_SWEEP) begin
				j_q <= j_q + 1'b1;
				if (row_last && !sweep_last) begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// Sweep datapath: left neighbor, diagonal and final distance.
	always_ff @(posedge clk) begin
		if (start) begin
			n1_q  <= cnt1_q;
			n2_q  <= cnt2_q;
			ovf_q <= drop_q;
			res_q <= cnt1_q + cnt2_q;
		end
		if (state_q == lvd_pkg::ST_ROW) begin
			left_q <= i_q;
			diag_q <= i_q - 1'b1;
		end
		if (state_q == lvd_pkg::ST_SWEEP) begin
			left_q <= cost;
			diag_q <= up;
			if (sweep_last) begin
				res_q <= cost;
			end
		end
	end

	// Output register, saturated to the result field.
	assign res_ext = XW'(res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_dist_q <= (res_ext > XW'(lvd_pkg::DIST_MAX)) ?
				lvd_pkg::DIST_MAX : res_ext[lvd_pkg::DIST_W-1:0];
			out_ovf_q  <= ovf_q;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.distance   = out_dist_q;
	assign rsp.overflowed = out_ovf_q;

	// Checks on counters, sweep indexes and the result bound.
	`LD_ASSERT(a_cnt_bound, (cnt1_q <= CW'(MAX_LEN)) && (cnt2_q <= CW'(MAX_LEN)), "string count above capacity")
	`LD_ASSERT(a_sweep_idx, (state_q == lvd_pkg::ST_SWEEP) |-> ((i_q >= CW'(1)) && (i_q <= n1_q) && (j_q >= CW'(1)) && (j_q <= n2_q)), "sweep index out of range")
	`LD_ASSERT(a_res_bound, (state_q == lvd_pkg::ST_RESULT) |-> ({1'b0, res_q} <= ({1'b0, n1_q} + {1'b0, n2_q})), "distance above total length")
	`LD_ASSERT_NEXT(a_clear, start, (cnt1_q == '0) && (cnt2_q == '0) && !drop_q, "stores not cleared after compute")

endmodule

/* sim/tb_levenshtein_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levenshtein distance engine testbench
// Loads pairs of 16-bit strings through the request channel and checks each
// distance beat against a single-row edit distance predictor. The directed
// beats cover empty strings, extreme symbols and the unused mode. The random
// pairs are mostly short, with a few full and overflowing strings. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_levenshtein_distance;

	localparam int MAX_LEN = 64;
	localparam int TARGET_BEATS = 1900;
	localparam int IDLE_LONG_MAX = 40;
	localparam logic [lvd_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	// Symbol choice for a generated pair.
	localparam int SYM_FULL = 0;
	localparam int SYM_ALPHABET = 1;
	localparam int SYM_DISJOINT = 2;

	typedef logic [lvd_pkg::SYM_W-1:0] sym_t;

	typedef struct {
		logic [lvd_pkg::MODE_W-1:0] mode;
		logic [lvd_pkg::SYM_W-1:0]  symbol;
	} char_beat_t;

	typedef struct {
		logic [lvd_pkg::DIST_W-1:0] distance;
		logic                       overflowed;
	} distance_beat_t;

	logic clk;
	logic arst_n;

	lvd_in_if  req_if ();
	lvd_out_if rsp_if ();

	levenshtein_distance #(
		.MAX_LEN(MAX_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	char_beat_t     send_queue[$];
	distance_beat_t distance_queue[$];

	// Predictor copy of the string stores and the drop flag.
	logic [lvd_pkg::SYM_W-1:0] first_text_q[$];
	logic [lvd_pkg::SYM_W-1:0] second_text_q[$];
	logic                      chars_dropped;

	int     error_count;
	longint cycle_count;
	longint cycle_limit;
	int     counted_beats;
	int     gen_first_len;
	int     gen_second_len;
	logic   beat_taken;

	logic [lvd_pkg::SYM_W-1:0] alphabet[4];
	int                        alphabet_size;

	int gap_left;
	int send_calm;
	int stall_left;
	int ready_calm;

	// Free-running clock, 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		error_count++;
	endtask

	// Idle length: mostly none or short, now and then long, with calm stretches.
	function automatic int idle_length(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, IDLE_LONG_MAX);
	endfunction

	// Edit distance of the stored strings with one row of costs.
	function automatic logic [lvd_pkg::DIST_W-1:0] edit_distance();
		int row[MAX_LEN+1];
		int n1, n2, diag, up, sub, best;
		n1 = first_text_q.size();
		n2 = second_text_q.size();
		for (int j = 0; j <= n2; j++)
			row[j] = j;
		for (int i = 1; i <= n1; i++) begin
			diag = row[0];
			row[0] = i;
			for (int j = 1; j <= n2; j++) begin
				up = row[j];
				sub = diag + ((first_text_q[i-1] == second_text_q[j-1]) ? 0 : 1);
				best = up + 1;
				if (row[j-1] + 1 < best)
					best = row[j-1] + 1;
				if (sub < best)
					best = sub;
				row[j] = best;
				diag = up;
			end
		end
		if (row[n2] > int'(lvd_pkg::DIST_MAX))
			return lvd_pkg::DIST_MAX;
		return row[n2][lvd_pkg::DIST_W-1:0];
	endfunction

	// Apply one accepted request beat to the predictor.
	task automatic predict_beat(input logic [lvd_pkg::MODE_W-1:0] mode,
		input logic [lvd_pkg::SYM_W-1:0] symbol);
		distance_beat_t result;
		case (mode)
			lvd_pkg::MODE_FIRST: begin
				if (first_text_q.size() < MAX_LEN)
					first_text_q.push_back(symbol);
				else
					chars_dropped = 1'b1;
			end
			lvd_pkg::MODE_SECOND: begin
				if (second_text_q.size() < MAX_LEN)
					second_text_q.push_back(symbol);
				else
					chars_dropped = 1'b1;
			end
			lvd_pkg::MODE_COMPUTE: begin
				result.distance = edit_distance();
				result.overflowed = chars_dropped;
				distance_queue.push_back(result);
				first_text_q.delete();
				second_text_q.delete();
				chars_dropped = 1'b0;
			end
			default: ;
		endcase
	endtask

	// Queue one beat and extend the cycle budget by its worst case.
	task automatic push_beat(input logic [lvd_pkg::MODE_W-1:0] mode,
		input logic [lvd_pkg::SYM_W-1:0] symbol);
		char_beat_t b;
		b.mode = mode;
		b.symbol = symbol;
		send_queue.push_back(b);
		cycle_limit += IDLE_LONG_MAX + 2;
		case (mode)
			lvd_pkg::MODE_FIRST: begin
				counted_beats++;
				if (gen_first_len < MAX_LEN)
					gen_first_len++;
			end
			lvd_pkg::MODE_SECOND: begin
				counted_beats++;
				if (gen_second_len < MAX_LEN)
					gen_second_len++;
			end
			lvd_pkg::MODE_COMPUTE: begin
				counted_beats++;
				cycle_limit += gen_first_len * (gen_second_len + 1) + 2 + IDLE_LONG_MAX + 2;
				gen_first_len = 0;
				gen_second_len = 0;
			end
			default: ;
		endcase
	endtask

	function automatic logic [lvd_pkg::SYM_W-1:0] pick_symbol(input int kind,
		input bit to_second);
		logic [lvd_pkg::SYM_W-1:0] s;
		case (kind)
			SYM_ALPHABET: s = alphabet[$urandom_range(0, alphabet_size - 1)];
			SYM_DISJOINT: begin
				s = sym_t'($urandom_range(0, 65535));
				s[0] = to_second;
			end
			default: s = sym_t'($urandom_range(0, 65535));
		endcase
		return s;
	endfunction

	// One pair of strings, interleaved at random, with a little noise mixed in.
	task automatic add_pair(input int n1, input int n2, input int kind, input bit with_compute);
		int left1, left2;
		bit to_second;
		left1 = n1;
		left2 = n2;
		if ($urandom_range(0, 3) == 0) begin
			alphabet[0] = 16'h0000;
			alphabet[1] = 16'hFFFF;
			alphabet_size = 2;
		end else begin
			foreach (alphabet[k])
				alphabet[k] = sym_t'($urandom_range(0, 65535));
			alphabet_size = $urandom_range(2, 4);
		end
		while (left1 + left2 > 0) begin
			if ($urandom_range(0, 99) < 3)
				push_beat(MODE_UNUSED, sym_t'($urandom_range(0, 65535)));
			to_second = (left1 == 0) || (left2 != 0 && $urandom_range(0, 1) == 1);
			if (to_second) begin
				push_beat(lvd_pkg::MODE_SECOND, pick_symbol(kind, 1'b1));
				left2--;
			end else begin
				push_beat(lvd_pkg::MODE_FIRST, pick_symbol(kind, 1'b0));
				left1--;
			end
		end
		if (with_compute)
			push_beat(lvd_pkg::MODE_COMPUTE, sym_t'($urandom_range(0, 65535)));
	endtask

	function automatic int pair_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 10);
		if (r < 95)
			return $urandom_range(11, 30);
		return $urandom_range(60, 70);
	endfunction

	// Request driver: holds a beat until taken, then idles or sends the next one.
	always @(negedge clk) begin
		if (arst_n && !(req_if.valid && !beat_taken)) begin
			if (gap_left > 0) begin
				req_if.valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (send_queue.size() != 0) begin
				req_if.valid <= 1'b1;
				req_if.mode <= send_queue[0].mode;
				req_if.symbol <= send_queue[0].symbol;
				void'(send_queue.pop_front());
				gap_left <= idle_length(send_calm);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Result sink: ready with random stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				rsp_if.ready <= 1'b1;
				stall_left <= idle_length(ready_calm);
			end
		end
	end

	// Monitor: check result beats, then feed accepted request beats to the predictor.
	always @(posedge clk) begin
		distance_beat_t want;
		if (arst_n) begin
			beat_taken <= req_if.valid && req_if.ready;
			if (rsp_if.valid && rsp_if.ready) begin
				if (distance_queue.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing pending, distance %0d",
						rsp_if.distance));
				end else begin
					want = distance_queue.pop_front();
					if (rsp_if.distance !== want.distance)
						report_mismatch($sformatf("distance %0d, predicted %0d",
							rsp_if.distance, want.distance));
					if (rsp_if.overflowed !== want.overflowed)
						report_mismatch($sformatf("overflowed %b, predicted %b",
							rsp_if.overflowed, want.overflowed));
				end
			end
			if (req_if.valid && req_if.ready)
				predict_beat(req_if.mode, req_if.symbol);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int pair_index;
		int n1, n2;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.mode = lvd_pkg::MODE_FIRST;
		req_if.symbol = '0;
		rsp_if.ready = 1'b0;
		beat_taken = 1'b0;
		chars_dropped = 1'b0;
		error_count = 0;
		cycle_count = 0;
		cycle_limit = 0;
		counted_beats = 0;
		gen_first_len = 0;
		gen_second_len = 0;
		gap_left = 0;
		send_calm = 0;
		stall_left = 0;
		ready_calm = 0;

		// Directed: both strings empty.
		push_beat(lvd_pkg::MODE_COMPUTE, 16'hFFFF);
		// Extreme symbols, one substitution.
		push_beat(lvd_pkg::MODE_FIRST, 16'h0000);
		push_beat(lvd_pkg::MODE_SECOND, 16'hFFFF);
		push_beat(lvd_pkg::MODE_COMPUTE, 16'h0000);
		// Second string empty.
		push_beat(lvd_pkg::MODE_FIRST, 16'hFFFF);
		push_beat(lvd_pkg::MODE_FIRST, 16'h0000);
		push_beat(lvd_pkg::MODE_FIRST, 16'h8001);
		push_beat(lvd_pkg::MODE_COMPUTE, 16'h0000);
		// First string empty.
		push_beat(lvd_pkg::MODE_SECOND, 16'h1234);
		push_beat(lvd_pkg::MODE_SECOND, 16'hFFFF);
		push_beat(lvd_pkg::MODE_COMPUTE, 16'h5555);
		// The unused mode changes nothing.
		push_beat(MODE_UNUSED, 16'hFFFF);
		push_beat(MODE_UNUSED, 16'h0000);
		// Equal strings with the unused mode in between.
		push_beat(lvd_pkg::MODE_FIRST, 16'hA5A5);
		push_beat(lvd_pkg::MODE_SECOND, 16'hA5A5);
		push_beat(lvd_pkg::MODE_FIRST, 16'h5A5A);
		push_beat(MODE_UNUSED, 16'h1111);
		push_beat(lvd_pkg::MODE_SECOND, 16'h5A5A);
		push_beat(lvd_pkg::MODE_COMPUTE, 16'h0000);
		// One deletion.
		push_beat(lvd_pkg::MODE_FIRST, 16'h0001);
		push_beat(lvd_pkg::MODE_FIRST, 16'h0002);
		push_beat(lvd_pkg::MODE_SECOND, 16'h0002);
		push_beat(lvd_pkg::MODE_COMPUTE, 16'h0000);

		// Random pairs; the first few force full strings and the widest distance.
		pair_index = 0;
		while (counted_beats < TARGET_BEATS) begin
			case (pair_index)
				0: add_pair(70, 66, SYM_FULL, 1'b1);
				1: add_pair(MAX_LEN, 0, SYM_ALPHABET, 1'b1);
				2: add_pair(MAX_LEN, MAX_LEN, SYM_DISJOINT, 1'b1);
				3: add_pair(0, MAX_LEN + 1, SYM_ALPHABET, 1'b1);
				default: begin
					n1 = pair_length();
					n2 = pair_length();
					add_pair(n1, n2, ($urandom_range(0, 3) == 0) ? SYM_FULL : SYM_ALPHABET,
						$urandom_range(0, 99) >= 4);
					// Now and then a second compute right after the first.
					if ($urandom_range(0, 49) == 0)
						push_beat(lvd_pkg::MODE_COMPUTE, sym_t'($urandom_range(0, 65535)));
				end
			endcase
			pair_index++;
		end
		push_beat(lvd_pkg::MODE_COMPUTE, sym_t'($urandom_range(0, 65535)));
		cycle_limit = 4 * cycle_limit + 20000;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (send_queue.size() != 0 || req_if.valid)
			@(posedge clk);
		while (distance_queue.size() != 0)
			@(posedge clk);
		repeat (MAX_LEN * (MAX_LEN + 1) + 2 * IDLE_LONG_MAX)
			@(posedge clk);

		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/lvd_pkg.sv
design/lvd_if.sv
design/levenshtein_distance.sv
sim/tb_levenshtein_distance.sv
